// ===== rtl/core/renc_pkg.sv =====
// Shared types and constants of the RV32I instruction encoder.
package renc_pkg;

    localparam int unsigned IN_DATA_W  = 120;
    localparam int unsigned IN_USER_W  = 4;
    localparam int unsigned OUT_DATA_W = 80;
    localparam int unsigned OUT_USER_W = 4;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_CODE_START = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LS_OFFSET  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LS_BASE    = 2'd2;

    localparam logic [6:0] OPCODE_BRANCH = 7'h63;
    localparam logic [6:0] OPCODE_JAL    = 7'h6F;
    localparam logic [6:0] OPCODE_JALR   = 7'h67;
    localparam logic [6:0] OPCODE_OP_IMM = 7'h13;
    localparam logic [6:0] OPCODE_OP     = 7'h33;
    localparam logic [6:0] OPCODE_LOAD   = 7'h03;
    localparam logic [6:0] OPCODE_STORE  = 7'h23;
    localparam logic [6:0] OPCODE_FENCE  = 7'h0F;

    localparam logic [2:0] F3_BEQ = 3'd0;
    localparam logic [2:0] F3_BNE = 3'd1;
    localparam logic [2:0] F3_ADD = 3'd0;
    localparam logic [2:0] F3_XOR = 3'd4;
    localparam logic [2:0] F3_OR  = 3'd6;
    localparam logic [2:0] F3_AND = 3'd7;
    localparam logic [2:0] F3_W   = 3'd2;

    localparam logic [31:0] FENCE_WORD = 32'h0ff0000f;

    typedef enum logic [3:0] {
        OP_BEQ   = 4'd0,
        OP_BNE   = 4'd1,
        OP_JMP   = 4'd2,
        OP_JAL   = 4'd3,
        OP_JALR  = 4'd4,
        OP_LIMM  = 4'd5,
        OP_XOR   = 4'd6,
        OP_ADD   = 4'd7,
        OP_OR    = 4'd8,
        OP_AND   = 4'd9,
        OP_LW    = 4'd10,
        OP_SW    = 4'd11,
        OP_FENCE = 4'd12
    } op_t;

    typedef enum logic [2:0] {
        FMT_NONE = 3'd0,
        FMT_R    = 3'd1,
        FMT_I    = 3'd2,
        FMT_S    = 3'd3,
        FMT_B    = 3'd4,
        FMT_J    = 3'd5
    } fmt_t;

    typedef enum logic [2:0] {
        IMM_ZERO,
        IMM_JUMP,
        IMM_JALR,
        IMM_LIMM,
        IMM_LS
    } imm_sel_t;

    typedef struct packed {
        fmt_t       fmt;
        logic [6:0] opc;
        logic [2:0] f3;
        logic       bad;
        logic [4:0] rd;
        logic [4:0] esrc;
        logic [4:0] rs2;
    } fields_t;

    typedef struct packed {
        fields_t     f;
        imm_sel_t    sel;
        logic [31:0] jump_imm;
        logic [31:0] jalr_a;
        logic [31:0] jalr_b;
        logic [31:0] lval;
        logic [31:0] ls_imm;
    } dec_t;

    typedef struct packed {
        fields_t     f;
        logic [31:0] imm;
    } imm_t;

endpackage

// ===== rtl/core/renc_decode.sv =====
// First stage: operation decode and the precomputed terms of every immediate.
module renc_decode (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [renc_pkg::IN_USER_W-1:0]      in_user,
    input  logic [renc_pkg::IN_DATA_W-1:0]      in_data,
    input  logic [31:0]                         code_start,
    input  logic [11:0]                         ls_offset,
    input  logic [4:0]                          ls_base,
    output logic                                out_valid,
    input  logic                                out_ready,
    output renc_pkg::dec_t                      out_dec
);

    logic           valid_reg;
    renc_pkg::dec_t dec_reg;
    renc_pkg::dec_t dec_next;
    renc_pkg::op_t  op;
    logic [4:0]     rd;
    logic [4:0]     rs1;
    logic [4:0]     rs2;
    logic [18:0]    offs;
    logic [31:0]    offs_ext;
    logic [31:0]    lval;
    logic [31:0]    rval;
    logic [9:0]     line;
    logic [8:0]     ment;
    logic [31:0]    line_sum;

    assign op       = renc_pkg::op_t'(in_user);
    assign rd       = in_data[4:0];
    assign rs1      = in_data[9:5];
    assign rs2      = in_data[14:10];
    assign offs     = in_data[33:15];
    assign lval     = in_data[65:34];
    assign rval     = in_data[97:66];
    assign line     = in_data[107:98];
    assign ment     = in_data[116:108];
    assign offs_ext = {{13{offs[18]}}, offs};
    assign line_sum = {22'd0, line} + offs_ext;

    always_comb begin
        dec_next          = '0;
        dec_next.jump_imm = {offs_ext[29:0], 2'b00};
        dec_next.jalr_a   = code_start - rval;
        dec_next.jalr_b   = {line_sum[29:0], 2'b00};
        dec_next.lval     = lval;
        dec_next.ls_imm   = {{20{ls_offset[11]}}, ls_offset} + {21'd0, ment, 2'b00};
        dec_next.f.rd     = rd;
        dec_next.f.rs2    = rs2;
        dec_next.f.fmt    = renc_pkg::FMT_NONE;
        dec_next.sel      = renc_pkg::IMM_ZERO;
        unique case (op)
            renc_pkg::OP_BEQ, renc_pkg::OP_BNE: begin
                dec_next.f.fmt  = renc_pkg::FMT_B;
                dec_next.f.opc  = renc_pkg::OPCODE_BRANCH;
                dec_next.f.f3   = (op == renc_pkg::OP_BEQ) ? renc_pkg::F3_BEQ
                                                           : renc_pkg::F3_BNE;
                dec_next.f.esrc = rs1;
                dec_next.sel    = renc_pkg::IMM_JUMP;
            end
            renc_pkg::OP_JMP, renc_pkg::OP_JAL: begin
                dec_next.f.fmt = renc_pkg::FMT_J;
                dec_next.f.opc = renc_pkg::OPCODE_JAL;
                dec_next.f.rd  = (op == renc_pkg::OP_JMP) ? 5'd0 : rd;
                dec_next.sel   = renc_pkg::IMM_JUMP;
            end
            renc_pkg::OP_JALR: begin
                dec_next.f.fmt  = renc_pkg::FMT_I;
                dec_next.f.opc  = renc_pkg::OPCODE_JALR;
                dec_next.f.esrc = rs1;
                dec_next.sel    = renc_pkg::IMM_JALR;
            end
            renc_pkg::OP_LIMM: begin
                dec_next.f.fmt = renc_pkg::FMT_I;
                dec_next.f.opc = renc_pkg::OPCODE_OP_IMM;
                dec_next.sel   = renc_pkg::IMM_LIMM;
            end
            renc_pkg::OP_XOR, renc_pkg::OP_ADD, renc_pkg::OP_OR, renc_pkg::OP_AND: begin
                dec_next.f.fmt  = renc_pkg::FMT_R;
                dec_next.f.opc  = renc_pkg::OPCODE_OP;
                dec_next.f.esrc = rs1;
                unique case (op)
                    renc_pkg::OP_XOR: dec_next.f.f3 = renc_pkg::F3_XOR;
                    renc_pkg::OP_OR:  dec_next.f.f3 = renc_pkg::F3_OR;
                    renc_pkg::OP_AND: dec_next.f.f3 = renc_pkg::F3_AND;
                    default:          dec_next.f.f3 = renc_pkg::F3_ADD;
                endcase
            end
            renc_pkg::OP_LW: begin
                dec_next.f.fmt  = renc_pkg::FMT_I;
                dec_next.f.opc  = renc_pkg::OPCODE_LOAD;
                dec_next.f.f3   = renc_pkg::F3_W;
                dec_next.f.esrc = ls_base;
                dec_next.sel    = renc_pkg::IMM_LS;
            end
            renc_pkg::OP_SW: begin
                dec_next.f.fmt  = renc_pkg::FMT_S;
                dec_next.f.opc  = renc_pkg::OPCODE_STORE;
                dec_next.f.f3   = renc_pkg::F3_W;
                dec_next.f.esrc = ls_base;
                dec_next.sel    = renc_pkg::IMM_LS;
            end
            renc_pkg::OP_FENCE: begin
                dec_next.f.opc = renc_pkg::OPCODE_FENCE;
            end
            default: begin
                dec_next.f.bad = 1'b1;
                dec_next.f.rd  = 5'd0;
                dec_next.f.rs2 = 5'd0;
            end
        endcase
    end

    assign in_ready = ~valid_reg | out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            dec_reg <= dec_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_dec   = dec_reg;

endmodule

// ===== rtl/core/renc_imm.sv =====
// Second stage: final immediate of each operation.
module renc_imm (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  renc_pkg::dec_t in_dec,
    output logic           out_valid,
    input  logic           out_ready,
    output renc_pkg::imm_t out_imm
);

    logic           valid_reg;
    renc_pkg::imm_t imm_reg;
    renc_pkg::imm_t imm_next;

    always_comb begin
        imm_next.f = in_dec.f;
        unique case (in_dec.sel)
            renc_pkg::IMM_JUMP: imm_next.imm = in_dec.jump_imm;
            renc_pkg::IMM_JALR: imm_next.imm = in_dec.jalr_a + in_dec.jalr_b;
            renc_pkg::IMM_LIMM: imm_next.imm = in_dec.lval;
            renc_pkg::IMM_LS:   imm_next.imm = in_dec.ls_imm;
            default:            imm_next.imm = 32'd0;
        endcase
    end

    assign in_ready = ~valid_reg | out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            imm_reg <= imm_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_imm   = imm_reg;

endmodule

// ===== rtl/core/renc_pack.sv =====
// Third stage: assembly of the machine word and the output register.
module renc_pack (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  renc_pkg::imm_t                     in_imm,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [renc_pkg::OUT_DATA_W-1:0]    out_data,
    output logic [renc_pkg::OUT_USER_W-1:0]    out_user
);

    logic                            valid_reg;
    logic [renc_pkg::OUT_DATA_W-1:0] data_reg;
    logic [renc_pkg::OUT_DATA_W-1:0] data_next;
    logic [renc_pkg::OUT_USER_W-1:0] user_reg;
    logic [renc_pkg::OUT_USER_W-1:0] user_next;
    logic [31:0]                     word;
    logic [31:0]                     imm;
    renc_pkg::fields_t               f;

    assign f   = in_imm.f;
    assign imm = in_imm.imm;

    always_comb begin
        unique case (f.fmt)
            renc_pkg::FMT_R: word = {7'd0, f.rs2, f.esrc, f.f3, f.rd, f.opc};
            renc_pkg::FMT_I: word = {imm[11:0], f.esrc, f.f3, f.rd, f.opc};
            renc_pkg::FMT_S: word = {imm[11:5], f.rs2, f.esrc, f.f3, imm[4:0], f.opc};
            renc_pkg::FMT_B: word = {imm[12], imm[10:5], f.rs2, f.esrc, f.f3,
                                     imm[4:1], imm[11], f.opc};
            renc_pkg::FMT_J: word = {imm[20], imm[10:1], imm[11], imm[19:12],
                                     f.rd, f.opc};
            default:         word = f.bad ? 32'd0 : renc_pkg::FENCE_WORD;
        endcase
    end

    assign data_next = {1'b0, f.esrc, imm, f.f3, f.opc, word};
    assign user_next = {f.bad, f.fmt};
    assign in_ready  = ~valid_reg | out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
            user_reg <= user_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;
    assign out_user  = user_reg;

endmodule

// ===== rtl/core/rv32i_instruction_encoder.sv =====
// Top level of the RV32I instruction encoder: configuration registers and three stages.
// Throughput is one word per cycle while m_tready stays high; each of the three stage registers holds one word,
// and a stage takes a new word whenever it is empty or its own word moves on.
// Reset clears the valid bit of every stage and sets all configuration registers to zero.
module rv32i_instruction_encoder (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // dest_reg, src1_reg, src2_reg, jump_offset, load_value, src1_value,
    // line_index, memory_entry, zero padding
    input  logic [renc_pkg::IN_DATA_W-1:0]     s_tdata,
    // operation
    input  logic [renc_pkg::IN_USER_W-1:0]     s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // machine_code, major_opcode, function_code, immediate_value, effective_src1,
    // zero padding
    output logic [renc_pkg::OUT_DATA_W-1:0]    m_tdata,
    // format_kind, unsupported
    output logic [renc_pkg::OUT_USER_W-1:0]    m_tuser,
    input  logic                               cfg_we,
    input  logic [renc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [renc_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    logic [31:0]    code_start_reg;
    logic [11:0]    ls_offset_reg;
    logic [4:0]     ls_base_reg;
    logic           dec_valid;
    logic           dec_ready;
    renc_pkg::dec_t dec;
    logic           imm_valid;
    logic           imm_ready;
    renc_pkg::imm_t imm;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            code_start_reg <= '0;
            ls_offset_reg  <= '0;
            ls_base_reg    <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                renc_pkg::CFG_CODE_START: code_start_reg <= cfg_wdata;
                renc_pkg::CFG_LS_OFFSET:  ls_offset_reg  <= cfg_wdata[11:0];
                renc_pkg::CFG_LS_BASE:    ls_base_reg    <= cfg_wdata[4:0];
                default: begin
                end
            endcase
        end
    end

    renc_decode u_decode (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_user    (s_tuser),
        .in_data    (s_tdata),
        .code_start (code_start_reg),
        .ls_offset  (ls_offset_reg),
        .ls_base    (ls_base_reg),
        .out_valid  (dec_valid),
        .out_ready  (dec_ready),
        .out_dec    (dec)
    );

    renc_imm u_imm (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (dec_valid),
        .in_ready  (dec_ready),
        .in_dec    (dec),
        .out_valid (imm_valid),
        .out_ready (imm_ready),
        .out_imm   (imm)
    );

    renc_pack u_pack (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (imm_valid),
        .in_ready  (imm_ready),
        .in_imm    (imm),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata),
        .out_user  (m_tuser)
    );

endmodule
